### src/meter_teleinfo_line_parser_unit_assert.svh
// Assertion macros used by the line parser's top-level RTL file.
`ifndef METER_TELEINFO_LINE_PARSER_UNIT_ASSERT_SVH
`define METER_TELEINFO_LINE_PARSER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MTLP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("line parser assertion failed");
`define MTLP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("line parser assertion failed");
`else
`define MTLP_ASSERT(lbl, clk, rstn, prop)
`define MTLP_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### src/mtlp_pkg.sv
// Package with character codes, keyword tables and lookup functions.
package mtlp_pkg;

  localparam logic [7:0] CH_STX   = 8'h02;
  localparam logic [7:0] CH_ETX   = 8'h03;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [39:0] NUM_MAX = 40'd999999999999;

  // Field codes of the keywords whose value is not numeric.
  localparam logic [4:0] FC_ADCO     = 5'd0;
  localparam logic [4:0] FC_OPTARIF  = 5'd1;
  localparam logic [4:0] FC_MOTDETAT = 5'd20;
  localparam logic [4:0] FC_PTEC     = 5'd21;
  localparam logic [4:0] FC_DEMAIN   = 5'd22;

  typedef enum logic [2:0] {
    KIND_TEXT, KIND_NUM, KIND_TARIFF, KIND_PERIOD, KIND_COLOUR
  } kind_e;

  // Keywords, right aligned and zero padded.
  localparam logic [63:0] KW_TAB [24] = '{
    64'("ADCO"), 64'("OPTARIF"), 64'("ISOUSC"), 64'("BASE"), 64'("HCHC"),
    64'("HCHP"), 64'("EJPHN"), 64'("EJPHM"), 64'("GAZ"), 64'("AUTRE"),
    64'("BBRHCJB"), 64'("BBRHPJB"), 64'("BBRHCJW"), 64'("BBRHPJW"),
    64'("BBRHCJR"), 64'("BBRHPJR"), 64'("PEJP"), 64'("IINST"), 64'("ADPS"),
    64'("IMAX"), 64'("MOTDETAT"), 64'("PTEC"), 64'("DEMAIN"), 64'("PAPP")
  };

  localparam logic [31:0] TARIFF_TAB [4] = '{"BASE", "HC..", "EJP.", "BBR("};
  localparam logic [31:0] PERIOD_TAB [11] = '{
    "TH..", "HC..", "HP..", "HN..", "PM..", "HCJB", "HPJB", "HCJW", "HPJW",
    "HCJR", "HPJR"
  };
  localparam logic [31:0] COLOUR_TAB [4] = '{"----", "BLEU", "BLAN", "ROUG"};

  typedef struct packed {
    logic       hit;
    logic [4:0] code;
  } kw_hit_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] code;
  } choice_hit_t;

  // Keyword search; the first match wins, as entries are unique.
  function automatic kw_hit_t kw_lookup(logic [63:0] kw);
    kw_hit_t r;
    r = '0;
    for (int i = 0; i < 24; i++) begin
      if (!r.hit && kw == KW_TAB[i]) begin
        r.hit  = 1'b1;
        r.code = 5'(i);
      end
    end
    return r;
  endfunction

  function automatic kind_e kw_kind(logic [4:0] code);
    case (code)
      FC_ADCO, FC_MOTDETAT: return KIND_TEXT;
      FC_OPTARIF:           return KIND_TARIFF;
      FC_PTEC:              return KIND_PERIOD;
      FC_DEMAIN:            return KIND_COLOUR;
      default:              return KIND_NUM;
    endcase
  endfunction

  // Choice search over the list that the keyword kind selects.
  function automatic choice_hit_t choice_lookup(kind_e kind, logic [31:0] v);
    choice_hit_t r;
    r = '0;
    case (kind)
      KIND_TARIFF: begin
        for (int i = 0; i < 4; i++)
          if (!r.hit && v == TARIFF_TAB[i]) begin
            r.hit = 1'b1; r.code = 4'(i);
          end
      end
      KIND_PERIOD: begin
        for (int i = 0; i < 11; i++)
          if (!r.hit && v == PERIOD_TAB[i]) begin
            r.hit = 1'b1; r.code = 4'(i);
          end
      end
      KIND_COLOUR: begin
        for (int i = 0; i < 4; i++)
          if (!r.hit && v == COLOUR_TAB[i]) begin
            r.hit = 1'b1; r.code = 4'(i);
          end
      end
      default: r.hit = 1'b1;
    endcase
    return r;
  endfunction

endpackage

### src/mtlp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mtlp_ram #(
  parameter int Width = 8,
  parameter int Depth = 29
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/meter_teleinfo_line_parser_unit.sv
// Top level of the meter teleinfo line parser.
// Takes one serial byte per beat. Until the first STX all bytes are ignored;
// afterwards ETX is ignored, ordinary bytes are appended to a line RAM of
// LINE_CHARS bytes (extra bytes are dropped), and LF starts a walk of the
// stored line with the input stalled. For each stored byte the walk goes
// through S_RD, which reads the registered line RAM, and S_PROC, which
// examines the byte; S_FIN then matches the keyword before the next byte is
// taken while the output register is free.
// A line with a known keyword and a valid value yields one result beat; the
// output register holds it while new bytes are taken, but the next result
// line then waits in its last cycle, with the input stalled, for as long as
// that earlier beat is not accepted.
`include "meter_teleinfo_line_parser_unit_assert.svh"
module meter_teleinfo_line_parser_unit
  import mtlp_pkg::*;
#(
  parameter int LINE_CHARS = 29,
  parameter int TEXT_CHARS = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [7:0] rx_byte
  input  logic [7:0]   s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [4:0] field_code, [44:5] numeric_value, [48:45] choice_code,
  // [112:49] text_value, [119:113] zero
  output logic [119:0] m_axis_tdata
);

  localparam int LW = $clog2(LINE_CHARS + 1);
  localparam int AW = $clog2(LINE_CHARS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_PROC = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  localparam logic [2:0] P_LEAD = 3'd0;
  localparam logic [2:0] P_KEY  = 3'd1;
  localparam logic [2:0] P_GAP  = 3'd2;
  localparam logic [2:0] P_VAL  = 3'd3;
  localparam logic [2:0] P_DONE = 3'd4;

  logic [1:0]    state_q, state_d;
  logic [2:0]    ph_q, ph_d;
  logic          synced_q, synced_d;
  logic [LW-1:0] len_q, len_d;
  logic [LW-1:0] idx_q, idx_d;
  logic [LW-1:0] vl_q, vl_d;
  logic [3:0]    kl_q, kl_d;
  logic [63:0]   kw_q, kw_d;
  logic [31:0]   v4_q, v4_d;
  logic [63:0]   txt_q, txt_d;
  logic [39:0]   num_q, num_d;
  logic          ngo_q, ngo_d;
  logic          ovalid_q, ovalid_d;
  logic [119:0]  odata_q, odata_d;

  logic          in_beat, we;
  logic [7:0]    rdata, c;
  logic [43:0]   num_next;
  kw_hit_t       kwh;
  kind_e         kind;
  choice_hit_t   ch;
  logic          res_ok;
  logic [63:0]   txt_mask;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign we            = in_beat && synced_q && s_axis_tdata != CH_ETX &&
                         s_axis_tdata != CH_LF && len_q < LW'(LINE_CHARS);

  mtlp_ram #(.Width(8), .Depth(LINE_CHARS)) u_line (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (len_q[AW-1:0]),
    .wdata_i (s_axis_tdata),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (rdata)
  );

  assign c        = rdata;
  assign num_next = ({4'd0, num_q} << 3) + ({4'd0, num_q} << 1) + 44'(c - CH_ZERO);

  // Keyword and choice matching on the collected tokens.
  always_comb begin
    kwh  = kw_lookup(kw_q);
    if (kl_q > 4'd8) kwh.hit = 1'b0;
    kind = kw_kind(kwh.code);
    ch   = choice_lookup(kind, (vl_q == LW'(4)) ? v4_q : 32'd0);
    res_ok = kwh.hit && vl_q != '0 && ch.hit;
    for (int i = 0; i < 8; i++) begin
      txt_mask[63-8*i -: 8] = (i < TEXT_CHARS) ? 8'hFF : 8'h00;
    end
  end

  // Sequencer: byte intake, line walk and result load.
  always_comb begin
    state_d  = state_q;
    ph_d     = ph_q;
    synced_d = synced_q;
    len_d    = len_q;
    idx_d    = idx_q;
    vl_d     = vl_q;
    kl_d     = kl_q;
    kw_d     = kw_q;
    v4_d     = v4_q;
    txt_d    = txt_q;
    num_d    = num_q;
    ngo_d    = ngo_q;
    ovalid_d = ovalid_q && !m_axis_tready;
    odata_d  = odata_q;
    case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          if (!synced_q) begin
            synced_d = (s_axis_tdata == CH_STX);
          end else if (s_axis_tdata == CH_LF) begin
            ph_d  = P_LEAD;
            idx_d = '0;
            vl_d  = '0;
            kl_d  = '0;
            kw_d  = '0;
            v4_d  = '0;
            txt_d = '0;
            num_d = '0;
            ngo_d = 1'b1;
            state_d = (len_q == '0) ? S_FIN : S_RD;
          end else if (we) begin
            len_d = len_q + LW'(1);
          end
        end
      end
      S_RD: state_d = S_PROC;
      S_PROC: begin
        if (c == 8'h00) begin
          state_d = S_FIN;
        end else begin
          idx_d   = idx_q + LW'(1);
          state_d = (idx_q + LW'(1) == len_q) ? S_FIN : S_RD;
          case (ph_q)
            P_LEAD, P_KEY: begin
              if (c == CH_SPACE) begin
                if (ph_q == P_KEY) ph_d = P_GAP;
              end else begin
                ph_d = P_KEY;
                kw_d = {kw_q[55:0], c};
                if (kl_q < 4'd9) kl_d = kl_q + 4'd1;
              end
            end
            P_GAP, P_VAL: begin
              if (c == CH_SPACE) begin
                if (ph_q == P_VAL) ph_d = P_DONE;
              end else begin
                ph_d = P_VAL;
                vl_d = vl_q + LW'(1);
                if (vl_q < LW'(4)) v4_d = {v4_q[23:0], c};
                if (vl_q < LW'(8)) txt_d[63 - 8*vl_q[2:0] -: 8] = c;
                if (ngo_q && c >= CH_ZERO && c <= CH_NINE) begin
                  num_d = (num_next > 44'(NUM_MAX)) ? NUM_MAX : num_next[39:0];
                end else begin
                  ngo_d = 1'b0;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_FIN: begin
        if (!res_ok) begin
          state_d = S_IDLE;
          len_d   = '0;
        end else if (!ovalid_q || m_axis_tready) begin
          state_d  = S_IDLE;
          len_d    = '0;
          ovalid_d = 1'b1;
          odata_d  = '0;
          odata_d[4:0]    = kwh.code;
          odata_d[44:5]   = (kind == KIND_NUM) ? num_q : 40'd0;
          odata_d[48:45]  = (kind == KIND_TARIFF || kind == KIND_PERIOD ||
                             kind == KIND_COLOUR) ? ch.code : 4'd0;
          odata_d[112:49] = (kind == KIND_TEXT) ? (txt_q & txt_mask) : 64'd0;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      synced_q <= 1'b0;
      len_q    <= '0;
      ovalid_q <= 1'b0;
      ph_q     <= P_LEAD;
      idx_q    <= '0;
    end else begin
      state_q  <= state_d;
      synced_q <= synced_d;
      len_q    <= len_d;
      ovalid_q <= ovalid_d;
      ph_q     <= ph_d;
      idx_q    <= idx_d;
    end
  end

  // Token and result payload registers.
  always_ff @(posedge clk_i) begin
    vl_q    <= vl_d;
    kl_q    <= kl_d;
    kw_q    <= kw_d;
    v4_q    <= v4_d;
    txt_q   <= txt_d;
    num_q   <= num_d;
    ngo_q   <= ngo_d;
    odata_q <= odata_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;

  `MTLP_ASSERT(a_idx_in_line, clk_i, rst_ni, (state_q != S_IDLE) |-> (idx_q <= len_q))
  `MTLP_ASSERT(a_no_write_in_walk, clk_i, rst_ni, we |-> (state_q == S_IDLE))
  `MTLP_ASSERT_NEXT(a_result_from_fin, clk_i, rst_ni,
    !(state_q == S_FIN) && !(ovalid_q && !m_axis_tready), !ovalid_q)

endmodule

### sim/tb_meter_teleinfo_line_parser_unit.sv
// Testbench for the teleinfo line parser: bytes before sync, directed lines, then random frames.
`timescale 1ns / 1ps
module tb_meter_teleinfo_line_parser_unit;
  import mtlp_pkg::*;

  localparam int LINE_CHARS = 29;
  localparam int TEXT_CHARS = 8;
  localparam logic [39:0] READING_MAX = 40'd999999999999;

  typedef struct packed {
    logic [4:0]  field_code;
    logic [39:0] numeric_value;
    logic [3:0]  choice_code;
    logic [63:0] text_value;
  } reading_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // [7:0] rx_byte
  logic [7:0]   s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // [4:0] field_code, [44:5] numeric_value, [48:45] choice_code,
  // [112:49] text_value, [119:113] zero
  logic [119:0] m_axis_tdata;

  // Predictor state, mirrors the block's line store.
  bit            in_sync;
  logic [7:0]    line_buf [LINE_CHARS];
  int            line_len;
  reading_t      pending_readings [$];
  int            error_count = 0;
  int            reading_count = 0;
  int            byte_count = 0;
  bit            hold_off = 1'b0;
  int            rx_cycle = 0;

  string kw_names [24] = '{"ADCO", "OPTARIF", "ISOUSC", "BASE", "HCHC", "HCHP",
    "EJPHN", "EJPHM", "GAZ", "AUTRE", "BBRHCJB", "BBRHPJB", "BBRHCJW", "BBRHPJW",
    "BBRHCJR", "BBRHPJR", "PEJP", "IINST", "ADPS", "IMAX", "MOTDETAT", "PTEC",
    "DEMAIN", "PAPP"};
  string tariffs [4] = '{"BASE", "HC..", "EJP.", "BBR("};
  string periods [11] = '{"TH..", "HC..", "HP..", "HN..", "PM..", "HCJB", "HPJB",
    "HCJW", "HPJW", "HCJR", "HPJR"};
  string colours [4] = '{"----", "BLEU", "BLAN", "ROUG"};

  meter_teleinfo_line_parser_unit #(
    .LINE_CHARS(LINE_CHARS),
    .TEXT_CHARS(TEXT_CHARS)
  ) i_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #4 clk_i = ~clk_i;

  // Classify a keyword index by the kind of value it carries.
  function automatic kind_e kind_of(int code);
    if (code == int'(FC_ADCO) || code == int'(FC_MOTDETAT)) return KIND_TEXT;
    if (code == int'(FC_OPTARIF)) return KIND_TARIFF;
    if (code == int'(FC_PTEC)) return KIND_PERIOD;
    if (code == int'(FC_DEMAIN)) return KIND_COLOUR;
    return KIND_NUM;
  endfunction

  // Compare a token of the stored line with a word.
  function automatic bit token_is(int start, int len, string w);
    if (len != w.len()) return 1'b0;
    for (int i = 0; i < len; i++)
      if (line_buf[start + i] != w[i]) return 1'b0;
    return 1'b1;
  endfunction

  // Parse the stored line at LF; queue a reading if the line is valid.
  task automatic parse_stored_line();
    int eol, i, ks, kl, vs, vl, code, choice;
    reading_t r;
    eol = 0; i = 0; code = -1; choice = 0; r = '0;
    while (eol < line_len && line_buf[eol] != 8'h00) eol++;
    while (i < eol && line_buf[i] == CH_SPACE) i++;
    ks = i;
    while (i < eol && line_buf[i] != CH_SPACE) i++;
    kl = i - ks;
    while (i < eol && line_buf[i] == CH_SPACE) i++;
    vs = i;
    while (i < eol && line_buf[i] != CH_SPACE) i++;
    vl = i - vs;
    if (kl == 0 || vl == 0) return;
    for (int k = 0; k < 24; k++)
      if (code < 0 && token_is(ks, kl, kw_names[k])) code = k;
    if (code < 0) return;
    case (kind_of(code))
      KIND_TEXT: begin
        for (int j = 0; j < vl && j < TEXT_CHARS; j++)
          r.text_value[(7 - j) * 8 +: 8] = line_buf[vs + j];
      end
      KIND_NUM: begin
        logic [43:0] acc;
        acc = '0;
        for (int j = 0; j < vl; j++) begin
          if (line_buf[vs + j] < CH_ZERO || line_buf[vs + j] > CH_NINE) break;
          acc = acc * 10 + (line_buf[vs + j] - CH_ZERO);
          if (acc > READING_MAX) acc = READING_MAX;
        end
        r.numeric_value = acc[39:0];
      end
      KIND_TARIFF: begin
        choice = -1;
        for (int k = 0; k < 4; k++)
          if (choice < 0 && token_is(vs, vl, tariffs[k])) choice = k;
      end
      KIND_PERIOD: begin
        choice = -1;
        for (int k = 0; k < 11; k++)
          if (choice < 0 && token_is(vs, vl, periods[k])) choice = k;
      end
      default: begin
        choice = -1;
        for (int k = 0; k < 4; k++)
          if (choice < 0 && token_is(vs, vl, colours[k])) choice = k;
      end
    endcase
    if (choice < 0) return;
    r.field_code = 5'(code);
    r.choice_code = 4'(choice);
    pending_readings.push_back(r);
  endtask

  // Advance the predictor by one accepted byte.
  task automatic predict_byte(logic [7:0] b);
    if (!in_sync) begin
      if (b == CH_STX) in_sync = 1'b1;
    end else if (b == CH_LF) begin
      parse_stored_line();
      line_len = 0;
    end else if (b != CH_ETX && line_len < LINE_CHARS) begin
      line_buf[line_len] = b;
      line_len++;
    end
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp_v);
    $display("mismatch %s: got %h expected %h at %0t", what, got, exp_v, $realtime);
    error_count++;
  endtask

  // Send one byte in bursts with random gaps; predicts on acceptance.
  task automatic send_byte(logic [7:0] b);
    bit rdy;
    if ($urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    // Ready is stable between rising edges, so sample it at the falling edge.
    rdy = 1'b0;
    while (!rdy) begin
      @(negedge clk_i);
      rdy = s_axis_tready;
      @(posedge clk_i);
    end
    predict_byte(b);
    byte_count++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_line(string s);
    send_text(s);
    send_byte(CH_LF);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    s_axis_tvalid <= 1'b0;
    while (pending_readings.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (2 * LINE_CHARS + 8) @(posedge clk_i);
  endtask

  // Check each result beat that the coming rising edge accepts.
  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      reading_t got, want;
      got = {m_axis_tdata[4:0], m_axis_tdata[44:5], m_axis_tdata[48:45],
             m_axis_tdata[112:49]};
      if (pending_readings.size() == 0) begin
        report_mismatch("unexpected beat", m_axis_tdata[63:0], '0);
      end else begin
        want = pending_readings.pop_front();
        reading_count++;
        if (got.field_code != want.field_code)
          report_mismatch("field_code", 64'(got.field_code), 64'(want.field_code));
        if (got.numeric_value != want.numeric_value)
          report_mismatch("numeric_value", 64'(got.numeric_value),
                          64'(want.numeric_value));
        if (got.choice_code != want.choice_code)
          report_mismatch("choice_code", 64'(got.choice_code), 64'(want.choice_code));
        if (got.text_value != want.text_value)
          report_mismatch("text_value", got.text_value, want.text_value);
        if (m_axis_tdata[119:113] != '0)
          report_mismatch("pad bits", 64'(m_axis_tdata[119:113]), '0);
      end
    end
  end

  // Receiver stall pattern, with a long hold-off when requested.
  always @(posedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    if (hold_off) m_axis_tready <= 1'b0;
    else if ((rx_cycle / 16) % 2 == 0) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(0, 3) != 0);
  end

  // Random value token of a given length, mostly digits.
  function automatic string rand_token(int len);
    string s;
    s = "";
    for (int i = 0; i < len; i++) begin
      byte c;
      c = ($urandom_range(0, 3) == 0) ? byte'($urandom_range(33, 126))
                                      : byte'($urandom_range(48, 57));
      s = {s, string'(c)};
    end
    return s;
  endfunction

  task automatic test_before_sync();
    send_line("PAPP 00120 *");
    send_byte(8'hFF);
    send_byte(CH_ETX);
    send_byte(CH_STX);
    drain();
  endtask

  task automatic test_directed_lines();
    send_line("ADCO 0123456789AB Z");
    send_line("MOTDETAT 000000 B");
    send_line("OPTARIF BBR( S");
    send_line("OPTARIF XXXX S");
    send_line("PTEC HPJR ;");
    send_line("DEMAIN ---- \"");
    send_line("DEMAIN ROUG +");
    send_line("BASE 9999999999999999 0");
    send_line("IINST -05 X");
    send_line("  PAPP   01230 ");
    send_line("FOO 123");
    send_line("HCHC");
    send_line("");
    send_text("IMAX 0");
    send_byte(CH_STX);
    send_byte(CH_ETX);
    send_line("42");
    send_text("ISOUSC 45");
    send_byte(8'h00);
    send_line("9");
    send_line("BBRHPJW 123456789012345678901234567890");
    send_line("ADCO 7");
    drain();
  endtask

  task automatic test_random_frames();
    int n;
    n = 0;
    while (byte_count < 1250) begin
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        int code;
        string val;
        code = $urandom_range(0, 23);
        case (kind_of(code))
          KIND_TARIFF: val = tariffs[$urandom_range(0, 3)];
          KIND_PERIOD: val = periods[$urandom_range(0, 10)];
          KIND_COLOUR: val = colours[$urandom_range(0, 3)];
          default: val = rand_token($urandom_range(1, 14));
        endcase
        send_line({kw_names[code], " ", val, " ", rand_token(1)});
      end else begin
        int len;
        len = $urandom_range(0, 34);
        for (int i = 0; i < len; i++) send_byte(8'($urandom_range(0, 255)));
        send_byte(CH_LF);
      end
      n++;
      if (n == 30) begin
        hold_off = 1'b1;
        fork
          begin
            repeat (400) @(posedge clk_i);
            hold_off = 1'b0;
          end
        join_none
      end
      if (n == 60) drain();
    end
    drain();
  endtask

  initial begin
    in_sync = 1'b0;
    line_len = 0;
    foreach (line_buf[i]) line_buf[i] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_before_sync();
    test_directed_lines();
    test_random_frames();
    $display("Covered %0d bytes: sync, every keyword kind, overflow, noise lines,",
             byte_count);
    $display("and %0d readings checked with receiver stalls.", reading_count);
    if (error_count == 0 && pending_readings.size() == 0)
      $display("tb_meter_teleinfo_line_parser_unit: PASS");
    else
      $display("tb_meter_teleinfo_line_parser_unit: FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_meter_teleinfo_line_parser_unit: FAIL");
    $finish;
  end

endmodule
